/* rtl/core/qotp_pkg.sv */
// Shared types and constants for the outline-to-path converter.
`timescale 1ns / 1ps

package qotp_pkg;

	localparam int COORD_BITS = 16;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef enum logic [1:0] {
		CMD_MOVE  = 2'd0,
		CMD_LINE  = 2'd1,
		CMD_CURVE = 2'd2,
		CMD_CLOSE = 2'd3
	} cmd_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   on;
	} point_t;

endpackage

/* rtl/core/qotp_point_if.sv */
// Outline point channel: valid/ready with one point per beat.
`timescale 1ns / 1ps

interface qotp_point_if;
	logic             valid;
	logic             ready;
	qotp_pkg::coord_t point_x;
	qotp_pkg::coord_t point_y;
	logic             on_curve;
	logic             contour_end;

	modport source (output valid, output point_x, output point_y, output on_curve,
		output contour_end, input ready);
	modport sink (input valid, input point_x, input point_y, input on_curve,
		input contour_end, output ready);
endinterface

/* rtl/core/qotp_cmd_if.sv */
// Path command channel: valid/ready with one command per beat.
`timescale 1ns / 1ps

interface qotp_cmd_if;
	logic             valid;
	logic             ready;
	qotp_pkg::cmd_t   command;
	qotp_pkg::coord_t first_x;
	qotp_pkg::coord_t first_y;
	qotp_pkg::coord_t end_x;
	qotp_pkg::coord_t end_y;
	logic             last_result;

	modport source (output valid, output command, output first_x, output first_y,
		output end_x, output end_y, output last_result, input ready);
	modport sink (input valid, input command, input first_x, input first_y,
		input end_x, input end_y, input last_result, output ready);
endinterface

/* rtl/core/quadratic_outline_to_path_top.sv */
// Outline point stream to move/line/curve/close path commands.
//
// Channels: outline takes one point per beat (x, y, on-curve tag, contour end mark);
// path gives one command per beat, last_result marking the final command of a point.
// A point enters an input register, the drawing steps for it are worked out in one
// pass of combinational logic, and up to five commands land together in a result
// register that the path side drains one per beat.
// The first command of a point is shown once the point has passed the input register
// and its commands have been loaded into the result register once that has freed.
// Throughput: one point per cycle while each point gives at most one command and
// the path stays ready; a point with more commands holds the result register until
// path has taken them all. The input register takes one more point while results wait.
// Points that give no command pass straight through without using the result register.
// Reset clears both registers and the contour point count; stored contour points
// need no clearing. When path stalls, the result register holds, then the input
// register fills and outline.ready drops until the result register frees.
`timescale 1ns / 1ps

module quadratic_outline_to_path_top (
	input logic         clk,
	input logic         arst_n,
	qotp_point_if.sink  outline,
	qotp_cmd_if.source  path
);

	localparam int NSLOT    = 6;
	localparam int SL_OPEN  = 0;
	localparam int SL_A_MV  = 1;
	localparam int SL_A_DR  = 2;
	localparam int SL_B_DR  = 3;
	localparam int SL_C_DR  = 4;
	localparam int SL_CLOSE = 5;
	localparam int CW       = qotp_pkg::COORD_BITS;

	typedef struct packed {
		qotp_pkg::cmd_t   command;
		qotp_pkg::coord_t fx;
		qotp_pkg::coord_t fy;
		qotp_pkg::coord_t ex;
		qotp_pkg::coord_t ey;
	} slot_t;

	typedef struct packed {
		logic  mv_v;
		slot_t mv;
		logic  dr_v;
		slot_t dr;
	} step_t;

	function automatic qotp_pkg::coord_t half_sum(qotp_pkg::coord_t a, qotp_pkg::coord_t b);
		logic signed [CW:0] s;
		s = {a[CW-1], a} + {b[CW-1], b};
		s = s + {{CW{1'b0}}, s[CW]};
		return s[CW:1];
	endfunction

	function automatic step_t do_step(qotp_pkg::point_t a, qotp_pkg::point_t b,
		qotp_pkg::point_t c, logic first);
		step_t r;
		r = '0;
		if (!a.on && !b.on) begin
			r.mv_v       = first;
			r.mv.command = qotp_pkg::CMD_MOVE;
			r.mv.fx      = half_sum(a.x, b.x);
			r.mv.fy      = half_sum(a.y, b.y);
		end
		if (!b.on) begin
			r.dr_v       = 1'b1;
			r.dr.command = qotp_pkg::CMD_CURVE;
			r.dr.fx      = b.x;
			r.dr.fy      = b.y;
			r.dr.ex      = c.on ? c.x : half_sum(b.x, c.x);
			r.dr.ey      = c.on ? c.y : half_sum(b.y, c.y);
		end else if (a.on) begin
			r.dr_v       = 1'b1;
			r.dr.command = qotp_pkg::CMD_LINE;
			r.dr.fx      = b.x;
			r.dr.fy      = b.y;
		end
		return r;
	endfunction

	qotp_pkg::point_t in_pt;
	logic             in_beat;
	logic             out_beat;

	qotp_pkg::point_t start_q, second_q, older_q, newer_q;
	logic [1:0]       ps_q;

	logic             valid_s1;
	logic             last_s1;
	logic [1:0]       ps_s1;
	qotp_pkg::point_t p_s1, start_s1, second_s1, older_s1, newer_s1;

	qotp_pkg::point_t a_a, a_b, a_c, b_a, b_b, b_c;
	logic             a_first, a_en, b_en, c_en;
	step_t            step_a, step_b, step_c;
	logic [NSLOT-1:0] mask_nx;
	slot_t            slot_nx [NSLOT];

	logic [NSLOT-1:0] mask_s2;
	slot_t            slot_s2 [NSLOT];
	logic [NSLOT-1:0] lowbit;
	slot_t            sel;
	logic             s2_free;
	logic             s1_adv;
	logic             s2_load;

	assign in_pt    = '{x: outline.point_x, y: outline.point_y, on: outline.on_curve};
	assign in_beat  = outline.valid && outline.ready;
	assign out_beat = path.valid && path.ready;

	// pick the window of each drawing step
	always_comb begin
		a_a     = p_s1;
		a_b     = p_s1;
		a_c     = p_s1;
		a_first = 1'b1;
		b_a     = p_s1;
		b_b     = start_s1;
		b_c     = p_s1;
		a_en    = last_s1;
		b_en    = 1'b0;
		c_en    = 1'b0;
		unique case (ps_s1) inside
			2'd0: begin
				a_en = last_s1;
			end
			2'd1: begin
				a_a  = start_s1;
				a_c  = start_s1;
				b_en = last_s1;
			end
			2'd2, 2'd3: begin
				a_a     = older_s1;
				a_b     = newer_s1;
				a_first = (ps_s1 == 2'd2);
				a_en    = 1'b1;
				b_a     = newer_s1;
				b_b     = p_s1;
				b_c     = start_s1;
				b_en    = last_s1;
				c_en    = last_s1;
			end
		endcase
	end

	assign step_a = do_step(a_a, a_b, a_c, a_first);
	assign step_b = do_step(b_a, b_b, b_c, 1'b0);
	assign step_c = do_step(p_s1, start_s1, second_s1, 1'b0);

	always_comb begin
		mask_nx           = '0;
		mask_nx[SL_OPEN]  = (ps_s1 == 2'd0);
		mask_nx[SL_A_MV]  = a_en && step_a.mv_v;
		mask_nx[SL_A_DR]  = a_en && step_a.dr_v;
		mask_nx[SL_B_DR]  = b_en && step_b.dr_v;
		mask_nx[SL_C_DR]  = c_en && step_c.dr_v;
		mask_nx[SL_CLOSE] = last_s1;

		slot_nx[SL_OPEN]         = '0;
		slot_nx[SL_OPEN].command = qotp_pkg::CMD_MOVE;
		slot_nx[SL_OPEN].fx      = p_s1.x;
		slot_nx[SL_OPEN].fy      = p_s1.y;
		slot_nx[SL_A_MV]         = step_a.mv;
		slot_nx[SL_A_DR]         = step_a.dr;
		slot_nx[SL_B_DR]         = step_b.dr;
		slot_nx[SL_C_DR]         = step_c.dr;
		slot_nx[SL_CLOSE]        = '0;
		slot_nx[SL_CLOSE].command = qotp_pkg::CMD_CLOSE;
	end

	assign lowbit  = mask_s2 & (~mask_s2 + NSLOT'(1));
	assign s2_free = (mask_s2 == '0) || (out_beat && (mask_s2 == lowbit));
	assign s1_adv  = valid_s1 && ((mask_nx == '0) || s2_free);
	assign s2_load = valid_s1 && (mask_nx != '0) && s2_free;

	assign outline.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mask_s2  <= '0;
			ps_q     <= 2'd0;
		end else begin
			if (outline.ready) begin
				valid_s1 <= outline.valid;
			end
			if (s2_load) begin
				mask_s2 <= mask_nx;
			end else if (out_beat) begin
				mask_s2 <= mask_s2 & ~lowbit;
			end
			if (in_beat) begin
				if (outline.contour_end) begin
					ps_q <= 2'd0;
				end else if (ps_q != 2'd3) begin
					ps_q <= ps_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			p_s1      <= in_pt;
			last_s1   <= outline.contour_end;
			ps_s1     <= ps_q;
			start_s1  <= start_q;
			second_s1 <= second_q;
			older_s1  <= older_q;
			newer_s1  <= newer_q;
			case (ps_q) inside
				2'd0: begin
					start_q <= in_pt;
				end
				2'd1: begin
					second_q <= in_pt;
					older_q  <= start_q;
					newer_q  <= in_pt;
				end
				default: begin
					older_q <= newer_q;
					newer_q <= in_pt;
				end
			endcase
		end
		if (s2_load) begin
			slot_s2 <= slot_nx;
		end
	end

	always_comb begin
		sel = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (lowbit[i]) begin
				sel = slot_s2[i];
			end
		end
	end

	assign path.valid       = (mask_s2 != '0);
	assign path.command     = sel.command;
	assign path.first_x     = sel.fx;
	assign path.first_y     = sel.fy;
	assign path.end_x       = sel.ex;
	assign path.end_y       = sel.ey;
	assign path.last_result = (mask_s2 == lowbit);

	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(path.valid && path.command == qotp_pkg::CMD_CLOSE) |-> path.last_result)
		else $error("close beat not marked last");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && path.last_result && !s2_load) |=> !path.valid)
		else $error("result register still valid after last beat");

	a_contour_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && outline.contour_end) |=> (ps_q == 2'd0))
		else $error("point count not cleared at contour end");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(mask_s2) <= 5)
		else $error("more than five commands pending");

endmodule

/* dv/qotp_path_checker.sv */
// Checker: watches the outline and path channels, predicts each command and compares.
`timescale 1ns / 1ps

module qotp_path_checker (
	input  logic  clk,
	input  logic  arst_n,
	qotp_point_if outline,
	qotp_cmd_if   path,
	output int    errors,
	output int    pending,
	output int    checked
);

	typedef struct {
		qotp_pkg::cmd_t   command;
		qotp_pkg::coord_t first_x;
		qotp_pkg::coord_t first_y;
		qotp_pkg::coord_t end_x;
		qotp_pkg::coord_t end_y;
		logic             last_result;
	} path_cmd_t;

	path_cmd_t        pending_cmds[$];
	qotp_pkg::point_t contour_start = '0;
	qotp_pkg::point_t contour_second = '0;
	qotp_pkg::point_t win_older = '0;
	qotp_pkg::point_t win_newer = '0;
	int unsigned      contour_count = 0;
	int               err_n = 0;
	int               chk_n = 0;

	function automatic qotp_pkg::coord_t midpoint(qotp_pkg::coord_t a, qotp_pkg::coord_t b);
		int s;
		s = int'(a) + int'(b);
		return qotp_pkg::coord_t'(s / 2);
	endfunction

	function automatic void add_cmd(qotp_pkg::cmd_t c, qotp_pkg::coord_t fx,
		qotp_pkg::coord_t fy, qotp_pkg::coord_t ex, qotp_pkg::coord_t ey);
		pending_cmds.push_back('{c, fx, fy, ex, ey, 1'b0});
	endfunction

	// one drawing step over three consecutive points
	function automatic void draw_span(qotp_pkg::point_t a, qotp_pkg::point_t b,
		qotp_pkg::point_t c, bit opening);
		if (!a.on && !b.on) begin
			a.x  = midpoint(a.x, b.x);
			a.y  = midpoint(a.y, b.y);
			a.on = 1'b1;
			if (opening)
				add_cmd(qotp_pkg::CMD_MOVE, a.x, a.y, '0, '0);
		end
		if (a.on && !b.on) begin
			if (c.on)
				add_cmd(qotp_pkg::CMD_CURVE, b.x, b.y, c.x, c.y);
			else
				add_cmd(qotp_pkg::CMD_CURVE, b.x, b.y, midpoint(b.x, c.x),
					midpoint(b.y, c.y));
		end else if (a.on && b.on) begin
			add_cmd(qotp_pkg::CMD_LINE, b.x, b.y, '0, '0);
		end
	endfunction

	function automatic void take_point(qotp_pkg::point_t p, logic closing);
		int base;
		base = pending_cmds.size();
		case (contour_count)
			0: begin
				contour_start = p;
				add_cmd(qotp_pkg::CMD_MOVE, p.x, p.y, '0, '0);
				if (closing) begin
					draw_span(p, p, p, 1'b1);
					add_cmd(qotp_pkg::CMD_CLOSE, '0, '0, '0, '0);
					contour_count = 0;
				end else begin
					contour_count = 1;
				end
			end
			1: begin
				contour_second = p;
				win_older      = contour_start;
				win_newer      = p;
				if (closing) begin
					draw_span(contour_start, p, contour_start, 1'b1);
					draw_span(p, contour_start, p, 1'b0);
					add_cmd(qotp_pkg::CMD_CLOSE, '0, '0, '0, '0);
					contour_count = 0;
				end else begin
					contour_count = 2;
				end
			end
			default: begin
				draw_span(win_older, win_newer, p, contour_count == 2);
				win_older = win_newer;
				win_newer = p;
				if (closing) begin
					draw_span(win_older, p, contour_start, 1'b0);
					draw_span(p, contour_start, contour_second, 1'b0);
					add_cmd(qotp_pkg::CMD_CLOSE, '0, '0, '0, '0);
					contour_count = 0;
				end else begin
					contour_count = 3;
				end
			end
		endcase
		if (pending_cmds.size() > base)
			pending_cmds[pending_cmds.size() - 1].last_result = 1'b1;
	endfunction

	task automatic report(string msg);
		$display("checker: beat %0d: %s", chk_n, msg);
		err_n++;
	endtask

	task automatic check_beat();
		path_cmd_t w;
		if (pending_cmds.size() == 0) begin
			report($sformatf("command %0d with nothing outstanding", path.command));
		end else begin
			w = pending_cmds.pop_front();
			if (path.command !== w.command)
				report($sformatf("command got %0d want %s", path.command, w.command.name()));
			if (path.first_x !== w.first_x)
				report($sformatf("first_x got %0d want %0d", path.first_x, w.first_x));
			if (path.first_y !== w.first_y)
				report($sformatf("first_y got %0d want %0d", path.first_y, w.first_y));
			if (path.end_x !== w.end_x)
				report($sformatf("end_x got %0d want %0d", path.end_x, w.end_x));
			if (path.end_y !== w.end_y)
				report($sformatf("end_y got %0d want %0d", path.end_y, w.end_y));
			if (path.last_result !== w.last_result)
				report($sformatf("last_result got %b want %b", path.last_result, w.last_result));
		end
		chk_n++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_cmds.delete();
			contour_start  = '0;
			contour_second = '0;
			win_older      = '0;
			win_newer      = '0;
			contour_count  = 0;
			errors  <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (outline.valid && outline.ready)
				take_point('{outline.point_x, outline.point_y, outline.on_curve},
					outline.contour_end);
			if (path.valid && path.ready)
				check_beat();
			errors  <= err_n;
			pending <= pending_cmds.size();
			checked <= chk_n;
		end
	end

endmodule

/* dv/tb.sv */
// Testbench top: clock, reset, outline point stimulus, path back-pressure and verdict.
`timescale 1ns / 1ps

module tb;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   checked;
	bit   calm = 1'b0;
	int   points_sent = 0;
	int   contours_sent = 0;
	int   drains = 0;

	qotp_point_if outline_ch();
	qotp_cmd_if   path_ch();

	quadratic_outline_to_path_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.outline (outline_ch),
		.path    (path_ch)
	);

	qotp_path_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.outline (outline_ch),
		.path    (path_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(0, 6));
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 7))
			0: return 32767;
			1: return -32768;
			2: return -int'($urandom_range(0, 1));
			3: return int'($urandom_range(0, 200)) - 100;
			default: return int'(qotp_pkg::coord_t'($urandom()));
		endcase
	endfunction

	task automatic send_point(int x, int y, logic on, logic closing);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			outline_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		outline_ch.valid       <= 1'b1;
		outline_ch.point_x     <= qotp_pkg::coord_t'(x);
		outline_ch.point_y     <= qotp_pkg::coord_t'(y);
		outline_ch.on_curve    <= on;
		outline_ch.contour_end <= closing;
		do @(posedge clk); while (!outline_ch.ready);
		points_sent++;
		if (closing)
			contours_sent++;
	endtask

	task automatic send_contour(int len, int on_pct);
		for (int i = 0; i < len; i++)
			send_point(pick_coord(), pick_coord(), $urandom_range(0, 99) < on_pct, i == len - 1);
	endtask

	// hold the outline side until every predicted command has come out
	task automatic drain();
		outline_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		drains++;
	endtask

	initial begin
		outline_ch.valid       <= 1'b0;
		outline_ch.point_x     <= '0;
		outline_ch.point_y     <= '0;
		outline_ch.on_curve    <= 1'b0;
		outline_ch.contour_end <= 1'b0;
	end

	initial begin
		int stall;
		path_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				path_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			path_ch.ready <= 1'b1;
			do @(posedge clk); while (!path_ch.valid);
		end
	end

	initial begin
		int len;
		int on_pct;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(32767, -32768, 1'b1, 1'b1);
		send_point(-32768, 32767, 1'b0, 1'b1);
		send_point(100, -100, 1'b1, 1'b0);
		send_point(-1, 1, 1'b1, 1'b1);
		send_point(32767, 32767, 1'b0, 1'b0);
		send_point(32767, 32767, 1'b0, 1'b1);
		send_point(-32768, -32768, 1'b1, 1'b0);
		send_point(-1, -1, 1'b0, 1'b1);
		send_point(5, -5, 1'b0, 1'b0);
		send_point(7, 8, 1'b1, 1'b1);
		send_point(-32768, -1, 1'b0, 1'b0);
		send_point(-1, -32768, 1'b0, 1'b0);
		send_point(3, -3, 1'b0, 1'b0);
		send_point(10, 20, 1'b1, 1'b0);
		send_point(-7, 9, 1'b0, 1'b1);
		send_point(0, 0, 1'b1, 1'b0);
		send_point(-5, -5, 1'b0, 1'b0);
		send_point(32767, -32768, 1'b1, 1'b0);
		send_point(-32768, 32767, 1'b1, 1'b0);
		send_point(11, -11, 1'b0, 1'b0);
		send_point(-3, 3, 1'b0, 1'b1);
		send_point(1, 1, 1'b0, 1'b0);
		send_point(-2, -2, 1'b0, 1'b0);
		send_point(3, -3, 1'b0, 1'b1);
		drain();

		while (points_sent < 360) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0:       len = 1;
				1:       len = 2;
				default: len = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 4))
				0:       on_pct = 0;
				1:       on_pct = 100;
				2:       on_pct = 30;
				3:       on_pct = 70;
				default: on_pct = 50;
			endcase
			send_contour(len, on_pct);
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		calm = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		$display("summary: %0d points in %0d contours, %0d commands checked, %0d drains",
			points_sent, contours_sent, checked, drains);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end

endmodule
